/* hw/rtl/ucrr_pkg.sv */
// Package for the USB control request responder.
// Holds request codes, the item and state structs and the endpoint slot lookup.
// No dependencies.
`default_nettype none

package ucrr_pkg;

    // Register map of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKEUP_ALLOWED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_POWERED   = 2'd1;

    localparam int SLOT_COUNT = 6;
    localparam int SLOT_W     = 3;

    // Request type field, bits 6..5 of bmRequestType
    localparam logic [1:0] TYPE_STANDARD = 2'b00;
    localparam logic [1:0] TYPE_VENDOR   = 2'b10;

    // Full bmRequestType values
    localparam logic [7:0] RT_DEV_OUT    = 8'h00;
    localparam logic [7:0] RT_EP_OUT     = 8'h02;
    localparam logic [7:0] RT_DEV_IN     = 8'h80;
    localparam logic [7:0] RT_IFACE_IN   = 8'h81;
    localparam logic [7:0] RT_EP_IN      = 8'h82;
    localparam logic [7:0] RT_VENDOR_OUT = 8'h40;
    localparam logic [7:0] RT_VENDOR_IN  = 8'hC0;

    // Standard request codes
    localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
    localparam logic [7:0] REQ_GET_DESC      = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
    localparam logic [7:0] REQ_GET_IFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_IFACE     = 8'd11;

    // Vendor request codes
    localparam logic [7:0] VREQ_RESET        = 8'd0;
    localparam logic [7:0] VREQ_MODEM_CTRL   = 8'd1;
    localparam logic [7:0] VREQ_FLOW_CTRL    = 8'd2;
    localparam logic [7:0] VREQ_BAUD_RATE    = 8'd3;
    localparam logic [7:0] VREQ_DATA_FMT     = 8'd4;
    localparam logic [7:0] VREQ_MODEM_STATUS = 8'd5;
    localparam logic [7:0] VREQ_EVENT_CHAR   = 8'd6;
    localparam logic [7:0] VREQ_ERROR_CHAR   = 8'd7;
    localparam logic [7:0] VREQ_SET_LATENCY  = 8'd9;
    localparam logic [7:0] VREQ_GET_LATENCY  = 8'd10;

    // Descriptor types in wValue high byte
    localparam logic [7:0] DT_DEVICE      = 8'd1;
    localparam logic [7:0] DT_CONFIG      = 8'd2;
    localparam logic [7:0] DT_STRING      = 8'd3;
    localparam logic [7:0] DT_QUALIFIER   = 8'd6;
    localparam logic [7:0] DT_OTHER_SPEED = 8'd7;

    // Descriptor selection codes
    localparam logic [2:0] SEL_NONE      = 3'd0;
    localparam logic [2:0] SEL_DEVICE    = 3'd1;
    localparam logic [2:0] SEL_QUALIFIER = 3'd2;
    localparam logic [2:0] SEL_CONFIG    = 3'd3;
    localparam logic [2:0] SEL_STRING0   = 3'd4;

    localparam logic [7:0] FEAT_EP_HALT      = 8'd0;
    localparam logic [7:0] FEAT_REMOTE_WAKE  = 8'd1;
    localparam logic [7:0] MAX_STRING_INDEX  = 8'd3;

    localparam logic [7:0] MODEM_STATUS_A = 8'h11;
    localparam logic [7:0] MODEM_STATUS_B = 8'h60;
    localparam logic [7:0] LATENCY_ON     = 8'd16;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_TWO  = 2'd2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [7:0] request_type;
        logic [7:0] request_code;
        logic [7:0] value_low;
        logic [7:0] value_high;
        logic [7:0] index_low;
    } t_req;

    typedef struct packed {
        logic              stall_res;
        logic [2:0]        descriptor_select;
        logic [1:0]        reply_length;
        logic [7:0]        reply_first;
        logic [7:0]        reply_second;
        logic              toggle_reset;
        logic [SLOT_W-1:0] endpoint_slot;
        logic              latency_enabled;
    } t_res;

    typedef struct packed {
        logic                  wakeup_allowed;
        logic                  self_powered;
        logic [7:0]            current_configuration;
        logic [7:0]            current_interface;
        logic                  wakeup_enabled;
        logic [SLOT_COUNT-1:0] endpoint_halted;
        logic [7:0]            latency_value;
    } t_state;

    typedef struct packed {
        logic              set_interface;
        logic              set_configuration;
        logic              wakeup_wr;
        logic              wakeup_val;
        logic              halt_wr;
        logic              halt_val;
        logic [SLOT_W-1:0] slot;
        logic              latency_wr;
        logic [7:0]        value;
    } t_upd;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_slot;

    // Endpoint address to slot; addresses past EP9 miss
    function automatic t_slot slot_lookup(input logic [7:0] addr);
        logic [6:0] idx;
        t_slot      s;
        idx    = {addr[6:1], (addr > 8'd128)};
        s.hit  = 1'b1;
        case (idx)
            7'd0:    s.slot = 3'd0;
            7'd1:    s.slot = 3'd1;
            7'd2:    s.slot = 3'd2;
            7'd3:    s.slot = 3'd2;
            7'd4:    s.slot = 3'd3;
            7'd5:    s.slot = 3'd3;
            7'd6:    s.slot = 3'd4;
            7'd7:    s.slot = 3'd4;
            7'd8:    s.slot = 3'd5;
            7'd9:    s.slot = 3'd5;
            default: begin
                s.hit  = 1'b0;
                s.slot = 3'd0;
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ucrr_decode.sv */
// Request decoder: one setup packet plus current state to one result and a state update.
// Purely combinational; uses ucrr_pkg.
`default_nettype none

module ucrr_decode (
    input  wire ucrr_pkg::t_req   i_req,
    input  wire ucrr_pkg::t_state i_state,
    output ucrr_pkg::t_res        o_res,
    output ucrr_pkg::t_upd        o_upd
);
    import ucrr_pkg::*;

    logic  ok;
    t_res  res;
    t_upd  upd;
    t_slot ep;

    assign ep = slot_lookup(i_req.index_low);

    always_comb begin
        ok        = 1'b1;
        res       = '0;
        upd       = '0;
        upd.value = i_req.value_low;
        upd.slot  = ep.slot;

        case (i_req.request_type[6:5])
            TYPE_STANDARD: begin
                case (i_req.request_code)
                    REQ_GET_DESC: begin
                        case (i_req.value_high)
                            DT_DEVICE:      res.descriptor_select = SEL_DEVICE;
                            DT_QUALIFIER:   res.descriptor_select = SEL_QUALIFIER;
                            DT_CONFIG:      res.descriptor_select = SEL_CONFIG;
                            DT_OTHER_SPEED: res.descriptor_select = SEL_CONFIG;
                            DT_STRING: begin
                                if (i_req.value_low > MAX_STRING_INDEX) begin
                                    ok = 1'b0;
                                end else begin
                                    res.descriptor_select =
                                        SEL_STRING0 + {1'b0, i_req.value_low[1:0]};
                                end
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                    REQ_GET_IFACE: begin
                        res.reply_length = LEN_ONE;
                        res.reply_first  = i_state.current_interface;
                    end
                    REQ_SET_IFACE:  upd.set_interface     = 1'b1;
                    REQ_SET_CONFIG: upd.set_configuration = 1'b1;
                    REQ_GET_CONFIG: begin
                        res.reply_length = LEN_ONE;
                        res.reply_first  = i_state.current_configuration;
                    end
                    REQ_GET_STATUS: begin
                        case (i_req.request_type)
                            RT_DEV_IN: begin
                                res.reply_length = LEN_TWO;
                                res.reply_first  = {6'd0, i_state.wakeup_enabled,
                                                    i_state.self_powered};
                            end
                            RT_IFACE_IN: res.reply_length = LEN_TWO;
                            RT_EP_IN: begin
                                if (!ep.hit) begin
                                    ok = 1'b0;
                                end else begin
                                    res.reply_length  = LEN_TWO;
                                    res.reply_first   =
                                        {7'd0, i_state.endpoint_halted[ep.slot]};
                                    res.endpoint_slot = ep.slot;
                                end
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                    REQ_CLEAR_FEATURE: begin
                        // other recipients are accepted and ignored
                        if (i_req.request_type == RT_DEV_OUT) begin
                            if (i_req.value_low != FEAT_REMOTE_WAKE) begin
                                ok = 1'b0;
                            end else begin
                                upd.wakeup_wr  = 1'b1;
                                upd.wakeup_val = 1'b0;
                            end
                        end else if (i_req.request_type == RT_EP_OUT) begin
                            if (i_req.value_low != FEAT_EP_HALT || !ep.hit) begin
                                ok = 1'b0;
                            end else begin
                                upd.halt_wr       = 1'b1;
                                upd.halt_val      = 1'b0;
                                res.toggle_reset  = 1'b1;
                                res.endpoint_slot = ep.slot;
                            end
                        end
                    end
                    REQ_SET_FEATURE: begin
                        if (i_req.request_type == RT_DEV_OUT) begin
                            if (i_req.value_low != FEAT_REMOTE_WAKE ||
                                !i_state.wakeup_allowed) begin
                                ok = 1'b0;
                            end else begin
                                upd.wakeup_wr  = 1'b1;
                                upd.wakeup_val = 1'b1;
                            end
                        end else if (i_req.request_type == RT_EP_OUT) begin
                            // halt whatever the feature selector says
                            if (!ep.hit) begin
                                ok = 1'b0;
                            end else begin
                                upd.halt_wr       = 1'b1;
                                upd.halt_val      = 1'b1;
                                res.endpoint_slot = ep.slot;
                            end
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    default: ok = 1'b0;
                endcase
            end
            TYPE_VENDOR: begin
                if (i_req.request_type == RT_VENDOR_OUT) begin
                    case (i_req.request_code)
                        VREQ_RESET, VREQ_MODEM_CTRL, VREQ_FLOW_CTRL, VREQ_BAUD_RATE,
                        VREQ_DATA_FMT, VREQ_EVENT_CHAR, VREQ_ERROR_CHAR: ok = 1'b1;
                        VREQ_SET_LATENCY: upd.latency_wr = 1'b1;
                        default:          ok = 1'b0;
                    endcase
                end else if (i_req.request_type == RT_VENDOR_IN) begin
                    case (i_req.request_code)
                        VREQ_MODEM_STATUS: begin
                            res.reply_length = LEN_TWO;
                            res.reply_first  = MODEM_STATUS_A;
                            res.reply_second = MODEM_STATUS_B;
                        end
                        VREQ_GET_LATENCY: begin
                            res.reply_length = LEN_ONE;
                            res.reply_first  = LATENCY_ON;
                        end
                        default: ok = 1'b0;
                    endcase
                end
            end
            default: ok = 1'b0;
        endcase

        if (!ok) begin
            res           = '0;
            res.stall_res = 1'b1;
            upd           = '0;
        end

        // flag reflects the latency after this request
        res.latency_enabled = upd.latency_wr ? (i_req.value_low == LATENCY_ON)
                                             : (i_state.latency_value == LATENCY_ON);
    end

    assign o_res = res;
    assign o_upd = upd;

endmodule

`default_nettype wire

/* hw/rtl/ucrr_state.sv */
// Device state registers: configuration port registers and request-driven state.
// Applies one decoder update per advancing item; uses ucrr_pkg.
`default_nettype none

module ucrr_state (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [ucrr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire                              i_cfg_data,
    input  wire                              i_upd_en,
    input  wire ucrr_pkg::t_upd              i_upd,
    output ucrr_pkg::t_state                 o_state
);
    import ucrr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAKEUP_ALLOWED: n_state.wakeup_allowed = i_cfg_data;
                CFG_SELF_POWERED:   n_state.self_powered   = i_cfg_data;
                default:            n_state = r_state;
            endcase
        end
        if (i_upd_en) begin
            if (i_upd.set_interface)     n_state.current_interface     = i_upd.value;
            if (i_upd.set_configuration) n_state.current_configuration = i_upd.value;
            if (i_upd.wakeup_wr)         n_state.wakeup_enabled        = i_upd.wakeup_val;
            if (i_upd.halt_wr)           n_state.endpoint_halted[i_upd.slot] = i_upd.halt_val;
            if (i_upd.latency_wr)        n_state.latency_value         = i_upd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

/* hw/rtl/usb_control_request_responder_top.sv */
// USB control request responder, top level: input register, decoder, state, result register.
// Depends on ucrr_pkg, ucrr_decode and ucrr_state.
//
// Accepts one setup packet per clock while the output side is not stalled and returns one
// result item for each, passing through the input register and then the result register.
// The input register and the result register are decoupled, so a new item is taken while a
// finished result still waits; the decode and the state update happen in the single cycle an
// item moves from the input register to the result register, so each item sees the state
// left by the item before it. Configuration writes are taken in any cycle and should only be
// issued while no item is in flight.
`default_nettype none

module usb_control_request_responder_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // request_type[7:0], request_code[15:8], value_low[23:16], value_high[31:24],
    // index_low[39:32]
    input  wire [ucrr_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // stall_res[0], descriptor_select[3:1], reply_length[5:4], reply_first[13:6],
    // reply_second[21:14], toggle_reset[22], endpoint_slot[25:23],
    // latency_enabled[26], zero[31:27]
    output logic [ucrr_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [ucrr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire                                 i_cfg_data
);
    import ucrr_pkg::*;

    t_req   r_in;
    logic   r_in_valid;
    t_res   r_out;
    logic   r_out_valid;
    t_res   dec_res;
    t_upd   dec_upd;
    t_state state;
    logic   s_accept;
    logic   advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.request_type <= i_s_axis_tdata[7:0];
            r_in.request_code <= i_s_axis_tdata[15:8];
            r_in.value_low    <= i_s_axis_tdata[23:16];
            r_in.value_high   <= i_s_axis_tdata[31:24];
            r_in.index_low    <= i_s_axis_tdata[39:32];
        end
    end

    ucrr_decode u_decode (
        .i_req   (r_in),
        .i_state (state),
        .o_res   (dec_res),
        .o_upd   (dec_upd)
    );

    ucrr_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_upd_en    (advance),
        .i_upd       (dec_upd),
        .o_state     (state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= dec_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.latency_enabled, r_out.endpoint_slot,
                              r_out.toggle_reset, r_out.reply_second, r_out.reply_first,
                              r_out.reply_length, r_out.descriptor_select,
                              r_out.stall_res};

    // latency flag in the result agrees with the latency register after the update
    a_latency_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.latency_enabled == (state.latency_value == LATENCY_ON)))
        else $error("latency flag disagrees with stored latency");

    // a rejected request carries no reply, descriptor or toggle reset
    a_stall_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stall_res) |->
            (r_out.reply_length == LEN_NONE && r_out.descriptor_select == SEL_NONE &&
             r_out.toggle_reset == 1'b0 && r_out.endpoint_slot == 3'd0))
        else $error("stalled result carries payload");

    a_reply_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.reply_length != 2'd3))
        else $error("reply length out of range");

    a_toggle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.toggle_reset) |->
            (r_out.endpoint_slot < SLOT_W'(SLOT_COUNT) && !r_out.stall_res))
        else $error("toggle reset on invalid slot");

    // a held input item is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_in_valid) |-> advance)
        else $error("input register overrun");

endmodule

`default_nettype wire
